FILE: rtl/pus_pkg.sv
// shared constants and types of the png scanline unfilter
package pus_pkg;

    localparam int MAX_ROW_PIXELS_DEF = 1024;
    localparam int MAX_ROW_BYTES_DEF  = 8192;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS   = 2'd2;

    localparam logic [1:0] CM_GRAY       = 2'd0;
    localparam logic [1:0] CM_RGB        = 2'd1;
    localparam logic [1:0] CM_GRAY_ALPHA = 2'd2;
    localparam logic [1:0] CM_RGBA       = 2'd3;

endpackage

FILE: rtl/pus_in_if.sv
// input channel: one stream byte per beat
interface pus_in_if;
    import pus_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

FILE: rtl/pus_out_if.sv
// output channel: one rebuilt byte per beat, with its pixel when pixel_valid is set
interface pus_out_if;
    import pus_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] recon_byte;
    logic              is_filter_byte;
    logic              row_last;
    logic              pixel_valid;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              bad_filter;

    modport source (output valid, output recon_byte, output is_filter_byte, output row_last,
                    output pixel_valid, output red, output green, output blue, output alpha,
                    output bad_filter, input ready);
    modport sink   (input valid, input recon_byte, input is_filter_byte, input row_last,
                    input pixel_valid, input red, input green, input blue, input alpha,
                    input bad_filter, output ready);
endinterface

FILE: rtl/png_scanline_unfilter_rgba.sv
// png scanline unfilter with expansion to 8-bit rgba, top level
// Takes one inflated stream byte per cycle unless the output stalls, and returns one
// result beat per byte, registered in the cycle after the byte is accepted. Each row
// begins with its filter-type byte (answered with is_filter_byte set), followed by
// row_pixels (clamped to 1..MAX_ROW_PIXELS) times bytes-per-pixel data bytes rebuilt
// with None, Sub, Up, Average or Paeth; pixel_valid marks the byte that completes a
// pixel, with the pixel in red/green/blue/alpha. The previous row is held in a
// MAX_ROW_BYTES deep single-port-write line store whose next entry is read ahead, so
// there are no bubbles at row ends; a waiting result lets the next byte in only as it
// is taken. No clearing pass is needed: the first row after image_start reads the row
// above as zero. Configuration is taken at once and must only be written between items.
module png_scanline_unfilter_rgba #(
    parameter int MAX_ROW_PIXELS = pus_pkg::MAX_ROW_PIXELS_DEF,
    parameter int MAX_ROW_BYTES  = pus_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pus_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pus_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    pus_in_if.sink                         i_in,
    pus_out_if.source                      o_out
);
    import pus_pkg::*;

    localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int PXW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS + 1) : 1;
    localparam int PW  = PXW + 4;

    localparam int CUT1 = MAX_ROW_BYTES;
    localparam int CUT2 = (MAX_ROW_BYTES / 2) * 2;
    localparam int CUT3 = (MAX_ROW_BYTES / 3) * 3;
    localparam int CUT4 = (MAX_ROW_BYTES / 4) * 4;
    localparam int CUT6 = (MAX_ROW_BYTES / 6) * 6;
    localparam int CUT8 = (MAX_ROW_BYTES / 8) * 8;

    typedef struct packed {
        logic [BYTE_W-1:0] recon_byte;
        logic              is_filter_byte;
        logic              row_last;
        logic              pixel_valid;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              bad_filter;
    } t_result;

    function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] c);
        logic signed [BYTE_W+2:0] da;
        logic signed [BYTE_W+2:0] db;
        logic signed [BYTE_W+2:0] dc;
        logic        [BYTE_W+2:0] pa;
        logic        [BYTE_W+2:0] pb;
        logic        [BYTE_W+2:0] pc;
        logic        [BYTE_W-1:0] pick;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            pick = a;
        end else if (pb <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

    // configuration
    logic [1:0]            r_color_mode;
    logic                  r_deep;
    logic [CFG_DAT_W-1:0]  r_row_pixels;

    // row state
    logic                  r_expect_filter, n_expect_filter;
    logic [AW-1:0]         r_x, n_x;
    logic [2:0]            r_pcount, n_pcount;
    logic                  r_first, n_first;
    logic                  r_err, n_err;
    t_filter               r_filter, n_filter;
    logic [BYTE_W-1:0]     r_left [8];
    logic [BYTE_W-1:0]     n_left [8];
    logic [BYTE_W-1:0]     r_ul [8];
    logic [BYTE_W-1:0]     n_ul [8];

    // line store
    logic [BYTE_W-1:0]     r_line [MAX_ROW_BYTES];
    logic [BYTE_W-1:0]     r_rd;

    // output register
    logic                  r_out_valid;
    t_result               r_out, n_res;

    logic                  accept;
    logic                  is_filter;
    logic                  st_we;
    logic [2:0]            chans;
    logic [3:0]            bpp;
    logic [31:0]           px32;
    logic [PXW-1:0]        px;
    logic [PW-1:0]         prod;
    logic [31:0]           stride32;
    logic [SW-1:0]         stride;
    logic                  past_pixel;
    logic [BYTE_W-1:0]     a, b, c, recon;
    logic [BYTE_W:0]       avg_sum;
    logic                  done, last, bad_kind;
    logic [BYTE_W-1:0]     left_upd [8];
    logic [BYTE_W-1:0]     ch0, ch1, ch2, ch3;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= CM_RGBA;
            r_deep       <= 1'b0;
            r_row_pixels <= CFG_DAT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLOR_MODE:   r_color_mode <= i_cfg_data[1:0];
                CFG_DEEP_SAMPLES: r_deep       <= i_cfg_data[0];
                CFG_ROW_PIXELS:   r_row_pixels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bytes per pixel and row stride
    always_comb begin
        case (r_color_mode)
            CM_GRAY:       chans = 3'd1;
            CM_RGB:        chans = 3'd3;
            CM_GRAY_ALPHA: chans = 3'd2;
            default:       chans = 3'd4;
        endcase
        bpp = r_deep ? {chans, 1'b0} : {1'b0, chans};

        if (r_row_pixels == '0) begin
            px32 = 32'd1;
        end else if (32'(r_row_pixels) > 32'(MAX_ROW_PIXELS)) begin
            px32 = 32'(MAX_ROW_PIXELS);
        end else begin
            px32 = 32'(r_row_pixels);
        end
        px   = px32[PXW-1:0];
        prod = PW'(px) * PW'(bpp);

        if (32'(prod) > 32'(MAX_ROW_BYTES)) begin
            case (bpp)
                4'd1:    stride32 = 32'(CUT1);
                4'd2:    stride32 = 32'(CUT2);
                4'd3:    stride32 = 32'(CUT3);
                4'd4:    stride32 = 32'(CUT4);
                4'd6:    stride32 = 32'(CUT6);
                default: stride32 = 32'(CUT8);
            endcase
        end else begin
            stride32 = 32'(prod);
        end
        stride = stride32[SW-1:0];
    end

    assign accept    = i_in.valid && i_in.ready;
    assign is_filter = i_in.image_start || r_expect_filter;
    assign st_we     = accept && !is_filter;
    assign bad_kind  = i_in.data_byte > BYTE_W'(FLT_PAETH);

    // byte reconstruction
    always_comb begin
        past_pixel = 32'(r_x) >= 32'(bpp);
        a = past_pixel ? r_left[r_pcount] : '0;
        b = !r_first ? r_rd : '0;
        c = (!r_first && past_pixel) ? r_ul[r_pcount] : '0;
        avg_sum = {1'b0, a} + {1'b0, b};
        case (r_filter)
            FLT_SUB:   recon = i_in.data_byte + a;
            FLT_UP:    recon = i_in.data_byte + b;
            FLT_AVG:   recon = i_in.data_byte + avg_sum[BYTE_W:1];
            FLT_PAETH: recon = i_in.data_byte + paeth_pick(a, b, c);
            default:   recon = i_in.data_byte;
        endcase

        done = ({1'b0, r_pcount} + 4'd1) >= bpp;
        last = (32'(r_x) + 32'd1) >= 32'(stride);

        for (int i = 0; i < 8; i++) begin
            left_upd[i] = r_left[i];
        end
        left_upd[r_pcount] = recon;

        ch0 = left_upd[0];
        ch1 = r_deep ? left_upd[2] : left_upd[1];
        ch2 = r_deep ? left_upd[4] : left_upd[2];
        ch3 = r_deep ? left_upd[6] : left_upd[3];
    end

    // next state and result
    always_comb begin
        n_expect_filter = r_expect_filter;
        n_x             = r_x;
        n_pcount        = r_pcount;
        n_first         = r_first;
        n_err           = r_err;
        n_filter        = r_filter;
        for (int i = 0; i < 8; i++) begin
            n_left[i] = r_left[i];
            n_ul[i]   = r_ul[i];
        end
        n_res = '0;

        if (accept) begin
            if (i_in.image_start) begin
                n_first = 1'b1;
                n_err   = 1'b0;
                for (int i = 0; i < 8; i++) begin
                    n_left[i] = '0;
                    n_ul[i]   = '0;
                end
            end
            if (is_filter) begin
                n_filter        = bad_kind ? FLT_NONE : t_filter'(i_in.data_byte[2:0]);
                n_err           = n_err || bad_kind;
                n_expect_filter = 1'b0;
                n_x             = '0;
                n_pcount        = '0;
                n_res.is_filter_byte = 1'b1;
            end else begin
                n_ul[r_pcount]   = b;
                n_left[r_pcount] = recon;
                n_pcount         = done ? 3'd0 : r_pcount + 3'd1;
                n_res.recon_byte = recon;
                if (done) begin
                    n_res.pixel_valid = 1'b1;
                    n_res.red         = ch0;
                    n_res.alpha       = 8'hFF;
                    case (r_color_mode)
                        CM_GRAY: begin
                            n_res.green = ch0;
                            n_res.blue  = ch0;
                        end
                        CM_RGB: begin
                            n_res.green = ch1;
                            n_res.blue  = ch2;
                        end
                        CM_GRAY_ALPHA: begin
                            n_res.green = ch0;
                            n_res.blue  = ch0;
                            n_res.alpha = ch1;
                        end
                        default: begin
                            n_res.green = ch1;
                            n_res.blue  = ch2;
                            n_res.alpha = ch3;
                        end
                    endcase
                end
                if (last) begin
                    n_res.row_last  = 1'b1;
                    n_expect_filter = 1'b1;
                    n_x             = '0;
                    n_pcount        = '0;
                    n_first         = 1'b0;
                end else begin
                    n_x = r_x + AW'(1);
                end
            end
            n_res.bad_filter = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_filter <= 1'b1;
            r_x             <= '0;
            r_pcount        <= '0;
            r_first         <= 1'b1;
            r_err           <= 1'b0;
            r_filter        <= FLT_NONE;
            for (int i = 0; i < 8; i++) begin
                r_left[i] <= '0;
                r_ul[i]   <= '0;
            end
        end else begin
            r_expect_filter <= n_expect_filter;
            r_x             <= n_x;
            r_pcount        <= n_pcount;
            r_first         <= n_first;
            r_err           <= n_err;
            r_filter        <= n_filter;
            for (int i = 0; i < 8; i++) begin
                r_left[i] <= n_left[i];
                r_ul[i]   <= n_ul[i];
            end
        end
    end

    // line store, read ahead at the next data position with write bypass
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_line[r_x] <= recon;
        end
        if (st_we && r_x == n_x) begin
            r_rd <= recon;
        end else begin
            r_rd <= r_line[n_x];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_res;
        end
    end

    assign i_in.ready           = !r_out_valid || o_out.ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.recon_byte     = r_out.recon_byte;
    assign o_out.is_filter_byte = r_out.is_filter_byte;
    assign o_out.row_last       = r_out.row_last;
    assign o_out.pixel_valid    = r_out.pixel_valid;
    assign o_out.red            = r_out.red;
    assign o_out.green          = r_out.green;
    assign o_out.blue           = r_out.blue;
    assign o_out.alpha          = r_out.alpha;
    assign o_out.bad_filter     = r_out.bad_filter;

    // checks
    a_filter_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_filter_byte |->
            r_out.recon_byte == '0 && !r_out.pixel_valid && !r_out.row_last)
        else $error("filter beat carries data");

    a_row_end_expects_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_filter && last |=> r_expect_filter && !r_first && r_pcount == '0)
        else $error("row end did not rearm filter byte");

    a_no_pixel_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.pixel_valid |->
            r_out.red == '0 && r_out.green == '0 && r_out.blue == '0 && r_out.alpha == '0)
        else $error("color without completed pixel");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(accept && i_in.image_start) |=> r_err)
        else $error("filter error dropped without image start");

endmodule
